FILE: rtl/core/slsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsu_pkg: shared types and constants of the sorted list unit
// Table depth, field widths, operation and status codes, and the structs
// passed between the control and the cell row.
// ----------------------------------------------------------------------------
package slsu_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VAL_W   = 32;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef logic signed [VAL_W-1:0] t_val;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FILL
    } t_state;

    typedef struct packed {
        logic              go;
        logic [FUNC_W-1:0] func;
        t_val              value;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  pos;
        logic [CNT_W-1:0]  count;
        t_val              smallest;
        t_val              largest;
        logic              empty;
    } t_res;

    typedef struct packed {
        logic ins;
        logic del;
        t_val value;
    } t_cell_ctl;

endpackage

FILE: rtl/core/slsu_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsu_req_if: request channel
// Valid/ready channel carrying one operation code and one signed value.
// ----------------------------------------------------------------------------
interface slsu_req_if;
    import slsu_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    t_val              value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

FILE: rtl/core/slsu_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsu_rsp_if: response channel
// Valid/ready channel carrying status, position and the table summary.
// ----------------------------------------------------------------------------
interface slsu_rsp_if;
    import slsu_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] entry_count;
    t_val               smallest;
    t_val               largest;
    logic               is_empty;

    modport source (output valid, output status, output position, output entry_count,
                    output smallest, output largest, output is_empty, input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    input smallest, input largest, input is_empty, output ready);
endinterface

FILE: rtl/core/slsu_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsu_cell: one slot of the sorted row
// Holds one entry, compares it with the broadcast value and shifts towards
// its left or right neighbour on insert or delete.
// ----------------------------------------------------------------------------
module slsu_cell import slsu_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_active,
    input  logic      i_left_lt,
    input  t_val      i_left_val,
    input  t_val      i_right_val,
    output logic      o_lt,
    output logic      o_bound,
    output logic      o_hit,
    output t_val      o_val
);

    t_val r_val;
    t_val n_val;

    always_comb begin
        o_lt    = i_active && (r_val < i_ctl.value);
        // first slot not below the value: insert point and first-equal candidate
        o_bound = i_left_lt && !o_lt;
        o_hit   = o_bound && i_active && (r_val == i_ctl.value);
        o_val   = r_val;
    end

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins) begin
            if (o_bound) begin
                n_val = i_ctl.value;
            end else if (!i_left_lt) begin
                n_val = i_left_val;
            end
        end else if (i_ctl.del && !o_lt) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

FILE: rtl/core/slsu_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsu_chain: row of cells with occupancy count
// Broadcasts the request value to every cell, encodes the boundary cell,
// applies insert or delete and reports the table summary.
// ----------------------------------------------------------------------------
module slsu_chain import slsu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    output t_res o_res
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [DEPTH-1:0] w_lt;
    logic [DEPTH-1:0] w_bound;
    logic [DEPTH-1:0] w_hit;
    t_val             w_val [DEPTH];
    t_cell_ctl        w_ctl;
    logic             w_full;
    logic             w_found;
    logic [IDX_W-1:0] w_bpos;
    logic [CNT_W-1:0] w_last;
    t_val             w_largest;
    logic             w_is_ins;
    logic             w_is_del;
    logic             w_is_srch;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic w_active;
        logic w_left_lt;
        t_val w_left_val;
        t_val w_right_val;

        assign w_active = CNT_W'(g) < r_count;

        if (g == 0) begin : g_head
            assign w_left_lt  = 1'b1;
            assign w_left_val = i_req.value;
        end else begin : g_body
            assign w_left_lt  = w_lt[g-1];
            assign w_left_val = w_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_val = w_val[g];
        end else begin : g_next
            assign w_right_val = w_val[g+1];
        end

        slsu_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_active    (w_active),
            .i_left_lt   (w_left_lt),
            .i_left_val  (w_left_val),
            .i_right_val (w_right_val),
            .o_lt        (w_lt[g]),
            .o_bound     (w_bound[g]),
            .o_hit       (w_hit[g]),
            .o_val       (w_val[g])
        );
    end

    always_comb begin
        w_is_ins  = i_req.func == FN_INSERT;
        w_is_del  = i_req.func == FN_DELETE;
        w_is_srch = i_req.func == FN_SEARCH;
        w_full    = r_count == CNT_W'(DEPTH);
        w_found   = |w_hit;
        w_ctl.ins   = i_req.go && w_is_ins && !w_full;
        w_ctl.del   = i_req.go && w_is_del && w_found;
        w_ctl.value = i_req.value;
    end

    always_comb begin
        w_bpos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_bpos = w_bpos | (w_bound[i] ? IDX_W'(i) : IDX_W'(0));
        end
    end

    always_comb begin
        w_last    = r_count - CNT_W'(1);
        w_largest = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_largest = w_largest | ((CNT_W'(i) == w_last) ? w_val[i] : t_val'(0));
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        o_res.status = ST_MISS;
        o_res.pos    = '0;
        if (w_is_ins) begin
            if (w_full) begin
                o_res.status = ST_FULL;
            end else begin
                o_res.status = ST_DONE;
                o_res.pos    = w_bpos;
            end
        end else if ((w_is_del || w_is_srch) && w_found) begin
            o_res.status = ST_DONE;
            o_res.pos    = w_bpos;
        end
        o_res.count    = r_count;
        o_res.empty    = r_count == '0;
        o_res.smallest = o_res.empty ? t_val'(0) : w_val[0];
        o_res.largest  = o_res.empty ? t_val'(0) : w_largest;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH)) else $error("entry count beyond depth");

    a_bound_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count < CNT_W'(DEPTH)) |-> $onehot(w_bound))
        else $error("row lost ascending order");

    a_hit_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit)) else $error("more than one first-equal cell");

    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the count");

endmodule

FILE: rtl/core/sorted_list_insert_delete_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_search_unit: bounded sorted table
// Insert, delete-first-equal and search on an ascending table of signed
// values held in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request word (func, value); o_rsp returns one response
//   word per request (status, position, entry_count, smallest, largest,
//   is_empty). Both are valid/ready; a word moves when valid and ready meet.
//   Each request passes, in order, the accept edge (S_IDLE), the edge on which
//   all cells compare the broadcast value and shift in parallel (S_EXEC), and
//   the edge that loads the output register (S_FILL). The response is held in
//   that register, and a new request is accepted only after S_FILL is left.
//   The cell row is the limit: it serves one request at a time and the
//   summary is read from it only after the shift.
//   A response held in the output register does not block the next request;
//   if the receiver stalls, the next request runs through the row and then
//   waits, with ready low, until the held word is taken.
//   Reset empties the table (count cleared) and drops any held response;
//   cell contents are left as they are and are never read while unused.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_search_unit import slsu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slsu_req_if.sink    i_req,
    slsu_rsp_if.source  o_rsp
);

    t_state             r_state;
    t_state             n_state;
    logic [FUNC_W-1:0]  r_func;
    t_val               r_value;
    logic [STAT_W-1:0]  r_status;
    logic [IDX_W-1:0]   r_pos;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [STAT_W-1:0]  r_o_status;
    logic [POS_W-1:0]   r_o_pos;
    logic [COUNT_W-1:0] r_o_count;
    t_val               r_o_small;
    t_val               r_o_large;
    logic               r_o_empty;
    logic               w_accept;
    logic               w_go;
    logic               w_load;
    t_req               w_req;
    t_res               w_res;
    logic [POS_W+IDX_W-1:0]   w_pos_ext;
    logic [COUNT_W+CNT_W-1:0] w_cnt_ext;

    slsu_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FILL;
            end
            S_FILL: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        i_req.ready = 1'b0;
        w_go        = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
            end
            S_EXEC: begin
                w_go = 1'b1;
            end
            S_FILL: begin
                w_load = !r_out_valid || o_rsp.ready;
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_accept     = i_req.valid && i_req.ready;
        w_req.go     = w_go;
        w_req.func   = r_func;
        w_req.value  = r_value;
        w_pos_ext    = {{POS_W{1'b0}}, r_pos};
        w_cnt_ext    = {{COUNT_W{1'b0}}, w_res.count};
        n_out_valid  = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= i_req.func;
            r_value <= i_req.value;
        end
        if (w_go) begin
            r_status <= w_res.status;
            r_pos    <= w_res.pos;
        end
        if (w_load) begin
            r_o_status <= r_status;
            r_o_pos    <= w_pos_ext[POS_W-1:0];
            r_o_count  <= w_cnt_ext[COUNT_W-1:0];
            r_o_small  <= w_res.smallest;
            r_o_large  <= w_res.largest;
            r_o_empty  <= w_res.empty;
        end
    end

    always_comb begin
        o_rsp.valid       = r_out_valid;
        o_rsp.status      = r_o_status;
        o_rsp.position    = r_o_pos;
        o_rsp.entry_count = r_o_count;
        o_rsp.smallest    = r_o_small;
        o_rsp.largest     = r_o_large;
        o_rsp.is_empty    = r_o_empty;
    end

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_EXEC) else $error("accepted word not executed");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_out_valid) else $error("loaded response not presented");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && r_out_valid && !o_rsp.ready) |=> r_state == S_FILL)
        else $error("pending response overwritten under stall");

endmodule
